>>> design/systolic_mac_array_step_unit_defines.svh
// Assertion macros shared by the checker of the systolic MAC array step unit.
// Included by files that assert; no other dependencies.
`ifndef SYSTOLIC_MAC_ARRAY_STEP_UNIT_DEFINES_SVH
`define SYSTOLIC_MAC_ARRAY_STEP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SMAC_ASSERT_IMP(NAME, CLK, RSTN, ANT, CON) \
    NAME: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANT) |-> (CON)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SMAC_ASSERT_NXT(NAME, CLK, RSTN, ANT, CON) \
    NAME: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANT) |=> (CON)) \
        else $error("assertion failed");

`endif

>>> design/smac_pkg.sv
// Types and constants for the systolic MAC array step unit.
// No dependencies; imported by the cell, the top level and the checker.
package smac_pkg;

    localparam int ROW_W   = 3;
    localparam int COL_W   = 3;
    localparam int DATA_W  = 8;
    localparam int SUM_W   = 32;
    localparam int SLOT_W  = 8;
    localparam int IDLE_W  = 7;
    localparam int VEC_W   = 64;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_STEP = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [ROW_W-1:0]         weight_row;
        logic [COL_W-1:0]         weight_col;
        logic signed [DATA_W-1:0] weight_value;
        logic [VEC_W-1:0]         row_inputs;
    } t_smac_in;

    typedef struct packed {
        logic [COL_W-1:0]        column;
        logic signed [SUM_W-1:0] column_sum;
        logic                    stored;
        logic [SLOT_W-1:0]       slot;
        logic                    slot_overflow;
        logic [IDLE_W-1:0]       idle_cells;
        logic                    done_res;
        logic                    last;
    } t_smac_out;

    typedef struct packed {
        logic step;
        logic load;
    } t_smac_cell_ctl;

endpackage

>>> design/smac_cell.sv
// One weight-stationary multiply-accumulate cell: weight and partial sum registers.
// Depends on smac_pkg.
module smac_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  smac_pkg::t_smac_cell_ctl        i_ctl,
    input  logic signed [smac_pkg::DATA_W-1:0] i_weight,
    input  logic signed [smac_pkg::DATA_W-1:0] i_act,
    input  logic [smac_pkg::SUM_W-1:0]      i_sum,
    output logic [smac_pkg::SUM_W-1:0]      o_upd,
    output logic                            o_idle
);
    import smac_pkg::*;

    logic signed [DATA_W-1:0]   r_w;
    logic [SUM_W-1:0]           r_s;
    logic signed [2*DATA_W-1:0] prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= '0;
            r_s <= '0;
        end else begin
            if (i_ctl.load) begin
                r_w <= i_weight;
            end
            if (i_ctl.step) begin
                r_s <= i_sum;
            end
        end
    end

    always_comb begin
        prod   = i_act * r_w;
        o_upd  = r_s + SUM_W'(prod);
        o_idle = (i_act == '0) || (r_w == '0);
    end

endmodule

>>> design/systolic_mac_array_step_unit.sv
// Top level of the systolic MAC array step unit: input register, cell grid, result drain.
// Depends on smac_pkg and smac_cell.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------
//  in      | to unit   | i_in_valid / o_in_stall | i_in_data  (t_smac_in)
//  out     | from unit | o_out_valid / i_out_stall | o_out_data (t_smac_out)
//
// A load beat is accepted every cycle unless a stalled step beat is held ahead of it.
// A step beat is applied to the whole grid at once and leaves ARRAY_DIM result beats;
// the next step is applied in the cycle its predecessor's last beat is taken, so a step
// waits until the single result port has drained the results of the one before it.
// The first result beat is registered when the step beat is applied to the grid.
// Reset clears weights, activations, sums and slot counters at once; no clearing pass.
module systolic_mac_array_step_unit #(
    parameter int ARRAY_DIM = 8,
    parameter int ACC_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  smac_pkg::t_smac_in  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output smac_pkg::t_smac_out o_out_data,
    input  logic                i_out_stall
);
    import smac_pkg::*;

    localparam int BEAT_W     = $clog2(ARRAY_DIM);
    localparam int CNT_W      = $clog2(ACC_DEPTH + 1);
    localparam int ROW_IDLE_W = $clog2(ARRAY_DIM + 1);

    logic     r_in_valid;
    t_smac_in r_in;
    logic     advance;
    logic     do_step;
    logic     take;
    logic     beat_last;

    logic signed [DATA_W-1:0] act_eff [ARRAY_DIM][ARRAY_DIM];
    logic signed [DATA_W-1:0] r_act   [ARRAY_DIM][1:ARRAY_DIM-1];
    logic [SUM_W-1:0]         upd     [ARRAY_DIM][ARRAY_DIM];
    logic                     idle    [ARRAY_DIM][ARRAY_DIM];

    logic [ROW_IDLE_W-1:0] n_row_idle [ARRAY_DIM];
    logic [ARRAY_DIM-2:0]  n_row_nz;
    logic [CNT_W-1:0]      r_cnt      [ARRAY_DIM];
    logic                  col_full   [ARRAY_DIM];
    logic                  col_store  [ARRAY_DIM];

    logic                  r_busy;
    logic [BEAT_W-1:0]     r_beat;
    logic [SUM_W-1:0]      r_bot      [ARRAY_DIM];
    logic                  r_store    [ARRAY_DIM];
    logic [SLOT_W-1:0]     r_slot     [ARRAY_DIM];
    logic                  r_full     [ARRAY_DIM];
    logic [ROW_IDLE_W-1:0] r_row_idle [ARRAY_DIM];
    logic [ARRAY_DIM-2:0]  r_row_nz;
    logic [IDLE_W-1:0]     idle_total;

    assign take       = r_busy && !i_out_stall;
    assign beat_last  = (r_beat == BEAT_W'(ARRAY_DIM - 1));
    assign advance    = r_in_valid
                        && ((r_in.action == ACTION_LOAD) || !r_busy || (take && beat_last));
    assign do_step    = advance && (r_in.action == ACTION_STEP);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    for (genvar r = 0; r < ARRAY_DIM; r++) begin : g_row
        for (genvar c = 0; c < ARRAY_DIM; c++) begin : g_col
            t_smac_cell_ctl   ctl;
            logic [SUM_W-1:0] sum_in;

            assign ctl.step = do_step;
            assign ctl.load = advance && (r_in.action == ACTION_LOAD)
                              && (r_in.weight_row == ROW_W'(r))
                              && (r_in.weight_col == COL_W'(c));

            if (c == 0) begin : g_inject
                assign act_eff[r][c] = r_in.row_inputs[DATA_W*r +: DATA_W];
            end else begin : g_shift
                assign act_eff[r][c] = r_act[r][c];
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_act[r][c] <= '0;
                    end else if (do_step) begin
                        r_act[r][c] <= act_eff[r][c-1];
                    end
                end
            end

            if (r == 0) begin : g_top
                assign sum_in = '0;
            end else begin : g_below
                assign sum_in = upd[r-1][c];
            end

            smac_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (ctl),
                .i_weight (r_in.weight_value),
                .i_act    (act_eff[r][c]),
                .i_sum    (sum_in),
                .o_upd    (upd[r][c]),
                .o_idle   (idle[r][c])
            );
        end
    end

    always_comb begin
        for (int r = 0; r < ARRAY_DIM; r++) begin
            n_row_idle[r] = '0;
            for (int c = 0; c < ARRAY_DIM; c++) begin
                n_row_idle[r] = n_row_idle[r] + ROW_IDLE_W'(idle[r][c]);
            end
        end
        for (int r = 0; r < ARRAY_DIM - 1; r++) begin
            n_row_nz[r] = 1'b0;
            for (int c = 0; c < ARRAY_DIM; c++) begin
                n_row_nz[r] = n_row_nz[r] | (|upd[r][c]);
            end
        end
        for (int c = 0; c < ARRAY_DIM; c++) begin
            col_full[c]  = (r_cnt[c] == CNT_W'(ACC_DEPTH));
            col_store[c] = (|upd[ARRAY_DIM-1][c]) && !col_full[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < ARRAY_DIM; c++) begin
                r_cnt[c] <= '0;
            end
        end else if (do_step) begin
            for (int c = 0; c < ARRAY_DIM; c++) begin
                if (col_store[c]) begin
                    r_cnt[c] <= r_cnt[c] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_beat <= '0;
        end else if (do_step) begin
            r_busy <= 1'b1;
            r_beat <= '0;
        end else if (take) begin
            if (beat_last) begin
                r_busy <= 1'b0;
            end else begin
                r_beat <= r_beat + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_step) begin
            for (int c = 0; c < ARRAY_DIM; c++) begin
                r_bot[c]   <= upd[ARRAY_DIM-1][c];
                r_store[c] <= col_store[c];
                r_slot[c]  <= col_full[c] ? SLOT_W'(ACC_DEPTH - 1) : SLOT_W'(r_cnt[c]);
                r_full[c]  <= col_full[c];
            end
            r_row_idle <= n_row_idle;
            r_row_nz   <= n_row_nz;
        end else if (take) begin
            for (int c = 0; c < ARRAY_DIM - 1; c++) begin
                r_bot[c]   <= r_bot[c+1];
                r_store[c] <= r_store[c+1];
                r_slot[c]  <= r_slot[c+1];
                r_full[c]  <= r_full[c+1];
            end
        end
    end

    always_comb begin
        idle_total = '0;
        for (int r = 0; r < ARRAY_DIM; r++) begin
            idle_total = idle_total + IDLE_W'(r_row_idle[r]);
        end
    end

    assign o_out_valid = r_busy;

    always_comb begin
        o_out_data.column        = COL_W'(r_beat);
        o_out_data.column_sum    = r_bot[0];
        o_out_data.stored        = r_store[0];
        o_out_data.slot          = r_slot[0];
        o_out_data.slot_overflow = r_full[0];
        o_out_data.idle_cells    = idle_total;
        o_out_data.done_res      = ~|r_row_nz;
        o_out_data.last          = beat_last;
    end

endmodule

>>> design/smac_checker.sv
// Port-level checker for the systolic MAC array step unit, with its bind.
// Depends on smac_pkg and systolic_mac_array_step_unit_defines.svh.
`include "systolic_mac_array_step_unit_defines.svh"

module smac_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input smac_pkg::t_smac_out o_out_data,
    input logic                i_out_stall
);
    import smac_pkg::*;

    logic out_take;
    logic in_take;

    assign out_take = o_out_valid && !i_out_stall;
    assign in_take  = i_in_valid && !o_in_stall;

    `SMAC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data))
    `SMAC_ASSERT_NXT(a_beats_follow, i_clk, i_rst_n, out_take && !o_out_data.last,
        o_out_valid && (o_out_data.column == $past(o_out_data.column) + 1'b1))
    `SMAC_ASSERT_NXT(a_step_summary, i_clk, i_rst_n, out_take && !o_out_data.last,
        (o_out_data.idle_cells == $past(o_out_data.idle_cells))
        && (o_out_data.done_res == $past(o_out_data.done_res)))
    `SMAC_ASSERT_IMP(a_first_column, i_clk, i_rst_n, $rose(o_out_valid),
        o_out_data.column == '0)
    `SMAC_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall && !in_take,
        o_out_valid)

endmodule

bind systolic_mac_array_step_unit smac_checker u_smac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

>>> sim/tb_top.sv
// Self-checking testbench for the systolic MAC array step unit: weight loads and array steps,
// each step's column results predicted in-bench and compared beat by beat.
// Depends on smac_pkg and the systolic_mac_array_step_unit RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import smac_pkg::*;

    localparam int DIM   = 8;
    localparam int DEPTH = 256;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_smac_in  in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    t_smac_out out_data;
    logic      out_stall = 1'b0;

    logic signed [DATA_W-1:0] weight_grid [DIM][DIM];
    logic signed [DATA_W-1:0] act_grid [DIM][DIM];
    logic signed [SUM_W-1:0]  sum_grid [DIM][DIM];
    int unsigned              slot_fill [DIM];
    t_smac_out                column_results_due [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    systolic_mac_array_step_unit #(
        .ARRAY_DIM(DIM),
        .ACC_DEPTH(DEPTH)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_data (out_data),
        .i_out_stall(out_stall)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic apply_array_beat(input t_smac_in beat);
        logic signed [SUM_W-1:0] bottom [DIM];
        logic signed [SUM_W-1:0] prod;
        int                      idle;
        bit                      all_zero;
        bit                      full;
        t_smac_out               res;
        idle     = 0;
        all_zero = 1'b1;
        if (beat.action == ACTION_LOAD) begin
            weight_grid[beat.weight_row][beat.weight_col] = beat.weight_value;
            return;
        end
        for (int r = 0; r < DIM; r++)
            act_grid[r][0] = beat.row_inputs[DATA_W*r +: DATA_W];
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                prod = act_grid[r][c] * weight_grid[r][c];
                if (act_grid[r][c] == 0 || weight_grid[r][c] == 0)
                    idle++;
                sum_grid[r][c] = sum_grid[r][c] + prod;
            end
        end
        for (int c = 0; c < DIM; c++)
            bottom[c] = sum_grid[DIM-1][c];
        for (int r = DIM - 1; r > 0; r--)
            for (int c = 0; c < DIM; c++)
                sum_grid[r][c] = sum_grid[r-1][c];
        for (int r = 0; r < DIM; r++) begin
            sum_grid[0][r] = '0;
            for (int c = DIM - 1; c > 0; c--)
                act_grid[r][c] = act_grid[r][c-1];
            act_grid[r][0] = '0;
        end
        for (int r = 0; r < DIM; r++)
            for (int c = 0; c < DIM; c++)
                if (sum_grid[r][c] != 0)
                    all_zero = 1'b0;
        for (int c = 0; c < DIM; c++) begin
            full              = (slot_fill[c] >= DEPTH);
            res.column        = COL_W'(c);
            res.column_sum    = bottom[c];
            res.stored        = (bottom[c] != 0) && !full;
            res.slot          = full ? SLOT_W'(DEPTH - 1) : SLOT_W'(slot_fill[c]);
            res.slot_overflow = full;
            res.idle_cells    = IDLE_W'(idle);
            res.done_res      = all_zero;
            res.last          = (c == DIM - 1);
            if (res.stored)
                slot_fill[c]++;
            column_results_due = {column_results_due, res};
        end
    endtask

    task automatic send_beat(input t_smac_in beat);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_array_beat(beat);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (column_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk) begin
        t_smac_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (column_results_due.size() == 0) begin
                $error("result beat with nothing pending: column %0d", out_data.column);
                mismatch_count++;
            end else begin
                want = column_results_due.pop_front();
                check_field("column", want.column, out_data.column);
                check_field("column_sum", want.column_sum, out_data.column_sum);
                check_field("stored", want.stored, out_data.stored);
                check_field("slot", want.slot, out_data.slot);
                check_field("slot_overflow", want.slot_overflow, out_data.slot_overflow);
                check_field("idle_cells", want.idle_cells, out_data.idle_cells);
                check_field("done_res", want.done_res, out_data.done_res);
                check_field("last", want.last, out_data.last);
            end
        end
    end

    function automatic logic [DATA_W-1:0] random_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)
            return '0;
        else if (pick < 25)
            return 8'h7f;
        else if (pick < 30)
            return 8'h80;
        return DATA_W'($urandom);
    endfunction

    function automatic t_smac_in load_beat(input int row, input int col,
                                           input logic [DATA_W-1:0] value);
        t_smac_in beat;
        beat.action       = ACTION_LOAD;
        beat.weight_row   = ROW_W'(row);
        beat.weight_col   = COL_W'(col);
        beat.weight_value = value;
        beat.row_inputs   = {$urandom, $urandom};
        return beat;
    endfunction

    function automatic t_smac_in step_beat(input logic [VEC_W-1:0] vec);
        t_smac_in beat;
        beat.action       = ACTION_STEP;
        beat.weight_row   = ROW_W'($urandom);
        beat.weight_col   = COL_W'($urandom);
        beat.weight_value = DATA_W'($urandom);
        beat.row_inputs   = vec;
        return beat;
    endfunction

    function automatic t_smac_in random_beat(input int step_pct);
        t_smac_in beat;
        beat = load_beat($urandom_range(DIM - 1), $urandom_range(DIM - 1), random_byte());
        if ($urandom_range(99) < step_pct) begin
            beat.action = ACTION_STEP;
            for (int r = 0; r < DIM; r++)
                beat.row_inputs[DATA_W*r +: DATA_W] = random_byte();
        end
        return beat;
    endfunction

    task automatic test_extremes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_beat(step_beat('0));
        send_beat(load_beat(0, 0, 8'h7f));
        send_beat(load_beat(DIM - 1, DIM - 1, 8'h80));
        send_beat(load_beat(0, DIM - 1, 8'hff));
        send_beat(load_beat(DIM - 1, 0, 8'h01));
        send_beat(load_beat(3, 4, 8'h80));
        send_beat(step_beat({DIM{8'h80}}));
        send_beat(step_beat({DIM{8'h7f}}));
        send_beat(step_beat({DIM{8'hff}}));
        send_beat(step_beat({(DIM/2){8'h7f, 8'h80}}));
        send_beat(load_beat(0, 0, 8'h00));
        repeat (DIM) send_beat(step_beat('0));
        wait_results_drained();
    endtask

    task automatic test_random_mix(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_beat(random_beat(75));
        wait_results_drained();
    endtask

    task automatic test_slot_saturation();
        logic [VEC_W-1:0] vec;
        logic [DATA_W-1:0] w;
        bit                open_slots;
        int                steps;
        send_idle_pct  = 0;
        recv_stall_pct = 12;
        for (int c = 0; c < DIM; c++) begin
            w = DATA_W'($urandom_range(1, 127));
            send_beat(load_beat(DIM - 1, c, $urandom_range(1) ? w : -w));
        end
        steps      = 0;
        open_slots = 1'b1;
        while (open_slots && steps < 700) begin
            vec = {$urandom, $urandom};
            vec[DATA_W*(DIM-1) +: DATA_W] = DATA_W'($urandom_range(1, 255));
            send_beat(step_beat(vec));
            steps++;
            open_slots = 1'b0;
            for (int c = 0; c < DIM; c++)
                if (slot_fill[c] < DEPTH)
                    open_slots = 1'b1;
        end
        repeat (12) send_beat(random_beat(90));
        wait_results_drained();
    endtask

    initial begin
        for (int r = 0; r < DIM; r++) begin
            slot_fill[r] = 0;
            for (int c = 0; c < DIM; c++) begin
                weight_grid[r][c] = '0;
                act_grid[r][c]    = '0;
                sum_grid[r][c]    = '0;
            end
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_random_mix(50, 0, 0);
        test_random_mix(50, 78, 0);
        test_random_mix(50, 0, 78);
        test_random_mix(50, 12, 12);
        test_slot_saturation();

        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && column_results_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
